>>> design/utt_pkg.sv
`default_nettype none

package utt_pkg;

  // Lead byte prefixes, matched on the top bits of the byte
  localparam logic [4:0] LEAD_FOUR  = 5'h1E;
  localparam logic [3:0] LEAD_THREE = 4'hE;
  localparam logic [2:0] LEAD_TWO   = 3'h6;

  localparam logic [15:0] BOM_UNIT  = 16'hFEFF;
  localparam logic [15:0] SURR_HIGH = 16'hD800;
  localparam logic [15:0] SURR_LOW  = 16'hDC00;
  localparam logic [20:0] SURR_BASE = 21'h010000;

  // Units caused by one input item, first unit in slot 0
  typedef struct packed {
    logic [1:0]        count;
    logic [2:0][15:0]  units;
  } bundle_t;

endpackage

`default_nettype wire

>>> design/utt_decode.sv
`default_nettype none

module utt_decode (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [7:0]      in_byte,
  output utt_pkg::bundle_t     bundle
);
  import utt_pkg::*;

  logic        mark_sent;
  logic [1:0]  bytes_left;
  logic [20:0] partial_point;
  logic [1:0]  bytes_left_next;
  logic [20:0] partial_point_next;

  logic        point_valid;
  logic [20:0] point;
  logic [20:0] gathered;
  logic [20:0] diff;
  logic [19:0] offset;
  logic        wide;
  logic [15:0] unit_a;
  logic [15:0] unit_b;
  logic [1:0]  point_count;

  assign gathered = {partial_point[14:0], in_byte[5:0]};

  always_comb begin
    bytes_left_next    = bytes_left;
    partial_point_next = partial_point;
    point_valid        = 1'b0;
    point              = gathered;
    if (bytes_left == 2'd0) begin
      priority if (in_byte[7:3] == LEAD_FOUR) begin
        bytes_left_next    = 2'd3;
        partial_point_next = {18'd0, in_byte[2:0]};
      end else if (in_byte[7:4] == LEAD_THREE) begin
        bytes_left_next    = 2'd2;
        partial_point_next = {17'd0, in_byte[3:0]};
      end else if (in_byte[7:5] == LEAD_TWO) begin
        bytes_left_next    = 2'd1;
        partial_point_next = {16'd0, in_byte[4:0]};
      end else begin
        point_valid = 1'b1;
        point       = {13'd0, in_byte};
      end
    end else begin
      // continuation: gather low six bits, prefix unchecked
      partial_point_next = gathered;
      bytes_left_next    = bytes_left - 2'd1;
      point_valid        = (bytes_left == 2'd1);
    end
  end

  // Surrogate split; offset cut to 20 bits
  assign wide   = |point[20:16];
  assign diff   = point - SURR_BASE;
  assign offset = diff[19:0];
  assign unit_a = wide ? (SURR_HIGH | {6'd0, offset[19:10]}) : point[15:0];
  assign unit_b = SURR_LOW | {6'd0, offset[9:0]};

  always_comb begin
    if (!point_valid) begin
      point_count = 2'd0;
    end else if (wide) begin
      point_count = 2'd2;
    end else begin
      point_count = 2'd1;
    end
    bundle.count = point_count + {1'b0, !mark_sent};
    if (!mark_sent) begin
      bundle.units = {unit_b, unit_a, BOM_UNIT};
    end else begin
      bundle.units = {16'd0, unit_b, unit_a};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mark_sent     <= 1'b0;
      bytes_left    <= 2'd0;
      partial_point <= 21'd0;
    end else if (accept) begin
      mark_sent     <= 1'b1;
      bytes_left    <= bytes_left_next;
      partial_point <= partial_point_next;
    end
  end

endmodule

`default_nettype wire

>>> design/utt_queue.sv
`default_nettype none

module utt_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire utt_pkg::bundle_t push_data,
  output logic                 full,
  input  wire logic            little_endian,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [15:0]          out_unit,
  output logic                 last
);
  import utt_pkg::*;

  bundle_t     slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic [1:0]  idx;
  bundle_t     head;
  logic [15:0] unit;
  logic        is_last;
  logic        pop;
  logic        advance;

  assign head      = slots[rd_ptr];
  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign is_last   = (idx == head.count - 2'd1);
  assign advance   = out_valid && out_ready;
  assign pop       = advance && is_last;
  assign last      = is_last;

  always_comb begin
    unique case (idx)
      2'd1:    unit = head.units[1];
      2'd2:    unit = head.units[2];
      default: unit = head.units[0];
    endcase
    out_unit = little_endian ? {unit[7:0], unit[15:8]} : unit;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
      idx    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (advance) begin
        if (is_last) begin
          idx    <= 2'd0;
          rd_ptr <= !rd_ptr;
        end else begin
          idx <= idx + 2'd1;
        end
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/utf8_to_utf16_transcoder_top.sv
// UTF-8 to UTF-16 transcoder.
// Input channel: in_valid/in_ready with one UTF-8 byte (in_byte) per item.
// Output channel: out_valid/out_ready with one UTF-16 unit (out_unit, first
// transmitted byte in bits 15:8) per item; last marks the final unit caused
// by an input byte. The very first byte after reset is preceded by a
// byte-order mark. Bytes that only open or extend a sequence give no output.
// Configuration: cfg_write loads cfg_data into the byte-order select
// (0 big-endian, 1 little-endian); write it only while the block is idle.
// An accepted byte's units are registered in the queue before they are offered.
// One byte per cycle while each yields at most one unit and out_ready is high;
// a byte with several units holds the output until all are taken. Decoded units
// wait in a two-entry queue, so in_ready depends only on queue occupancy
// and input continues while the receiver holds a finished unit.
// A receiver stall holds out_unit and last; once both queue entries fill,
// in_ready drops until one drains.
// Reset (rst, synchronous) empties the queue, clears the sequence state,
// re-arms the byte-order mark and selects big-endian order.
`default_nettype none

module utf8_to_utf16_transcoder_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_unit,
  output logic             last
);
  import utt_pkg::*;

  logic    little_endian;
  logic    accept;
  logic    full;
  bundle_t bundle;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      little_endian <= 1'b0;
    end else if (cfg_write) begin
      little_endian <= cfg_data;
    end
  end

  utt_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_byte),
    .bundle  (bundle)
  );

  // drop bytes that only advance a sequence
  utt_queue u_queue (
    .clk           (clk),
    .rst           (rst),
    .push          (accept && (bundle.count != 2'd0)),
    .push_data     (bundle),
    .full          (full),
    .little_endian (little_endian),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_unit      (out_unit),
    .last          (last)
  );

endmodule

`default_nettype wire

>>> design/utt_checker.sv
`default_nettype none

module utt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_unit,
  input wire logic        last
);

  // a stalled unit holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_unit) && $stable(last))
    else $error("output unit changed while stalled");

  // units of one byte follow each other without a gap
  a_group_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid)
    else $error("unit group broken before last");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_reset_ready: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("input not ready right after reset");

endmodule

bind utf8_to_utf16_transcoder_top utt_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_unit  (out_unit),
  .last      (last)
);

`default_nettype wire

>>> tb/sv/tb_utf8_to_utf16_transcoder_top.sv
module tb_utf8_to_utf16_transcoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import utt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_BYTES = 88;
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    logic [15:0] unit;
    logic        last;
  } unit_item_t;

  // One row of the directed table; typed rows carry the units by hand
  typedef struct packed {
    logic [7:0]  in_byte;
    logic        typed;
    logic [1:0]  n_units;
    logic [15:0] unit0;
    logic [15:0] unit1;
  } dir_row_t;

  localparam int DIR_COUNT = 25;
  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    '{8'h00, 1'b1, 2'd2, 16'hFEFF, 16'h0000},
    '{8'h7F, 1'b1, 2'd1, 16'h007F, 16'h0000},
    '{8'h80, 1'b1, 2'd1, 16'h0080, 16'h0000},
    '{8'hBF, 1'b1, 2'd1, 16'h00BF, 16'h0000},
    '{8'hF8, 1'b1, 2'd1, 16'h00F8, 16'h0000},
    '{8'hFF, 1'b1, 2'd1, 16'h00FF, 16'h0000},
    '{8'hC2, 1'b0, 2'd0, 16'h0000, 16'h0000},
    '{8'hA9, 1'b0, 2'd0, 16'h0000, 16'h0000},
    '{8'hE2, 1'b0, 2'd0, 16'h0000, 16'h0000},
    '{8'h82, 1'b0, 2'd0, 16'h0000, 16'h0000},
    '{8'hAC, 1'b0, 2'd0, 16'h0000, 16'h0000},
    '{8'hED, 1'b0, 2'd0, 16'h0000, 16'h0000},
    '{8'hA0, 1'b0, 2'd0, 16'h0000, 16'h0000},
    '{8'h80, 1'b0, 2'd0, 16'h0000, 16'h0000},
    '{8'hF0, 1'b0, 2'd0, 16'h0000, 16'h0000},
    '{8'h9F, 1'b0, 2'd0, 16'h0000, 16'h0000},
    '{8'h98, 1'b0, 2'd0, 16'h0000, 16'h0000},
    '{8'h80, 1'b0, 2'd0, 16'h0000, 16'h0000},
    '{8'hF7, 1'b0, 2'd0, 16'h0000, 16'h0000},
    '{8'hBF, 1'b0, 2'd0, 16'h0000, 16'h0000},
    '{8'hBF, 1'b0, 2'd0, 16'h0000, 16'h0000},
    '{8'hBF, 1'b1, 2'd2, 16'hDBBF, 16'hDFFF},
    '{8'hE2, 1'b0, 2'd0, 16'h0000, 16'h0000},
    '{8'hF0, 1'b0, 2'd0, 16'h0000, 16'h0000},
    '{8'hC3, 1'b0, 2'd0, 16'h0000, 16'h0000}
  };

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic        cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_unit;
  logic        last;

  utf8_to_utf16_transcoder_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_unit  (out_unit),
    .last      (last)
  );

  // Predictor state
  logic             little_endian_sel;
  logic             mark_done;
  logic [1:0]       cont_left;
  logic [20:0]      point_acc;
  logic [2:0][15:0] decoded_units;
  int               decoded_count;

  unit_item_t  expected_units [$];
  logic [7:0]  stream_bytes [$];

  int fail_count;
  int cycle_count;
  int bytes_sent;
  int units_seen;
  int pairs_predicted;
  int order_writes;
  bit send_rush;
  bit recv_rush;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d units outstanding",
               cycle_count, expected_units.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: %s: got %h, want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic logic [15:0] order_unit(input logic [15:0] u);
    return little_endian_sel ? {u[7:0], u[15:8]} : u;
  endfunction

  function automatic void put_unit(input logic [15:0] u);
    decoded_units[decoded_count] = order_unit(u);
    decoded_count++;
  endfunction

  function automatic void put_point(input logic [20:0] cp);
    logic [19:0] offset;
    if (cp[20:16] == 5'd0) begin
      put_unit(cp[15:0]);
    end else begin
      // wrap the surrogate offset to twenty bits
      offset = 20'(cp - SURR_BASE);
      put_unit(SURR_HIGH | {6'd0, offset[19:10]});
      put_unit(SURR_LOW | {6'd0, offset[9:0]});
      pairs_predicted++;
    end
  endfunction

  function automatic void decode_utf8_byte(input logic [7:0] b);
    decoded_count = 0;
    if (!mark_done) begin
      put_unit(BOM_UNIT);
      mark_done = 1'b1;
    end
    if (cont_left == 2'd0) begin
      if (b[7:3] == LEAD_FOUR) begin
        cont_left = 2'd3;
        point_acc = {18'd0, b[2:0]};
      end else if (b[7:4] == LEAD_THREE) begin
        cont_left = 2'd2;
        point_acc = {17'd0, b[3:0]};
      end else if (b[7:5] == LEAD_TWO) begin
        cont_left = 2'd1;
        point_acc = {16'd0, b[4:0]};
      end else begin
        put_point({13'd0, b});
      end
    end else begin
      // gather six bits, prefix unchecked
      point_acc = {point_acc[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) put_point(point_acc);
    end
  endfunction

  function automatic int draw_wait(input bit rush);
    return rush ? 0 : $urandom_range(0, 9);
  endfunction

  task automatic send_byte(input dir_row_t row);
    int gap;
    gap = draw_wait(send_rush);
    if ($urandom_range(0, 29) == 0) send_rush = !send_rush;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= row.in_byte;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    decode_utf8_byte(row.in_byte);
    if (row.typed) begin
      if (row.n_units != 2'd0) expected_units.push_back('{row.unit0, row.n_units == 2'd1});
      if (row.n_units == 2'd2) expected_units.push_back('{row.unit1, 1'b1});
    end else begin
      for (int i = 0; i < decoded_count; i++)
        expected_units.push_back('{decoded_units[i], i == decoded_count - 1});
    end
  endtask

  // Hold off input until every outstanding unit has drained
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_units.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_byte_order(input logic le);
    cfg_write <= 1'b1;
    cfg_data <= le;
    @(posedge clk);
    cfg_write <= 1'b0;
    little_endian_sel = le;
    order_writes++;
  endtask

  function automatic logic [7:0] cont_byte(input logic [5:0] bits);
    // mostly well-formed, sometimes a bad prefix
    if ($urandom_range(0, 7) == 0) return {2'($urandom), bits};
    return {2'b10, bits};
  endfunction

  function automatic void queue_char();
    logic [20:0] cp;
    int kind;
    int cut;
    cp = 21'($urandom);
    kind = $urandom_range(0, 19);
    if (kind < 5) begin
      stream_bytes.push_back({1'b0, cp[6:0]});
    end else if (kind < 9) begin
      stream_bytes.push_back({3'b110, cp[10:6]});
      stream_bytes.push_back(cont_byte(cp[5:0]));
    end else if (kind < 13) begin
      stream_bytes.push_back({4'b1110, cp[15:12]});
      stream_bytes.push_back(cont_byte(cp[11:6]));
      stream_bytes.push_back(cont_byte(cp[5:0]));
    end else if (kind < 17) begin
      stream_bytes.push_back({5'b11110, cp[20:18]});
      stream_bytes.push_back(cont_byte(cp[17:12]));
      stream_bytes.push_back(cont_byte(cp[11:6]));
      stream_bytes.push_back(cont_byte(cp[5:0]));
    end else if (kind == 17) begin
      stream_bytes.push_back(8'($urandom));
    end else if (kind == 18) begin
      // stray continuation or F8..FF
      if (cp[0]) stream_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
      else stream_bytes.push_back(8'($urandom_range(8'hF8, 8'hFF)));
    end else begin
      // cut a sequence short; the next lead lands inside it
      cut = $urandom_range(0, 2);
      if (cut == 0) stream_bytes.push_back({3'b110, cp[4:0]});
      else if (cut == 1) stream_bytes.push_back({4'b1110, cp[3:0]});
      else stream_bytes.push_back({5'b11110, cp[2:0]});
      for (int i = 0; i < cut; i++) stream_bytes.push_back(cont_byte(6'($urandom)));
    end
  endfunction

  initial begin
    unit_item_t want;
    int stall;
    out_ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      stall = draw_wait(recv_rush);
      if ($urandom_range(0, 29) == 0) recv_rush = !recv_rush;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      units_seen++;
      if (expected_units.size() == 0) begin
        report_mismatch("unit with none outstanding", out_unit, 16'h0000);
      end else begin
        want = expected_units.pop_front();
        if (out_unit !== want.unit) report_mismatch("out_unit", out_unit, want.unit);
        if (last !== want.last) report_mismatch("last", {15'd0, last}, {15'd0, want.last});
      end
    end
  end

  initial begin
    logic [4:0] order_plan;
    dir_row_t   row;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_data <= 1'b0;
    in_valid <= 1'b0;
    in_byte <= 8'h00;
    little_endian_sel = 1'b0;
    mark_done = 1'b0;
    cont_left = 2'd0;
    point_acc = 21'd0;
    send_rush = 1'b0;
    recv_rush = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_COUNT; i++) send_byte(DIR_ROWS[i]);

    // alternate byte order between phases; a phase may end mid-sequence
    order_plan = 5'b10101;
    for (int p = 0; p < 5; p++) begin
      wait_drained();
      set_byte_order(order_plan[p]);
      stream_bytes.delete();
      while (stream_bytes.size() < PHASE_BYTES) queue_char();
      // leave the stream with an unfinished sequence
      if (p == 4) stream_bytes.push_back({4'b1110, 4'($urandom)});
      while (stream_bytes.size() != 0) begin
        row = '{stream_bytes.pop_front(), 1'b0, 2'd0, 16'h0000, 16'h0000};
        send_byte(row);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("covered %0d bytes, %0d units (%0d surrogate pairs), %0d byte-order writes",
             bytes_sent, units_seen, pairs_predicted, order_writes);
    $display("mismatches: %0d", fail_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
design/utt_pkg.sv
design/utt_decode.sv
design/utt_queue.sv
design/utf8_to_utf16_transcoder_top.sv
design/utt_checker.sv
tb/sv/tb_utf8_to_utf16_transcoder_top.sv
